/* hdl/interrupt_halt_register_block_top_macros.svh */
// assertion macros for the checker file of the interrupt/halt register block
// depends on nothing; include by bare file name
`ifndef INTERRUPT_HALT_REGISTER_BLOCK_TOP_MACROS_SVH
`define INTERRUPT_HALT_REGISTER_BLOCK_TOP_MACROS_SVH

// property checked outside reset
`define IHRB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked also during reset
`define IHRB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/ihrb_pkg.sv */
// shared types and register map of the interrupt/halt register block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ihrb_pkg;

  // byte addresses are carried one bit wider so that a + 3 never wraps
  localparam int ADDR_W = 11;
  localparam int OFFS_W = 10;
  localparam int DATA_W = 32;
  localparam int REQ_W  = 16;

  // register map
  localparam logic [ADDR_W-1:0] A_EN        = 11'h200;
  localparam logic [ADDR_W-1:0] A_EN_HI     = 11'h201;
  localparam logic [ADDR_W-1:0] A_IF        = 11'h202;
  localparam logic [ADDR_W-1:0] A_IF_HI     = 11'h203;
  localparam logic [ADDR_W-1:0] A_WAIT      = 11'h204;
  localparam logic [ADDR_W-1:0] A_WAIT_HI   = 11'h205;
  localparam logic [ADDR_W-1:0] A_WAIT_END  = 11'h206;
  localparam logic [ADDR_W-1:0] A_IME       = 11'h208;
  localparam logic [ADDR_W-1:0] A_IME_HI    = 11'h209;
  localparam logic [ADDR_W-1:0] A_IME_END   = 11'h20A;
  localparam logic [ADDR_W-1:0] A_POST      = 11'h300;
  localparam logic [ADDR_W-1:0] A_HALT      = 11'h301;
  localparam logic [ADDR_W-1:0] A_POST_END  = 11'h302;

  localparam int HALT_STOP_BIT = 7;
  localparam int IME_ON_BIT    = 0;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_IRQ   = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  typedef struct packed {
    kind_t              kind;
    logic [OFFS_W-1:0]  addr_offset;
    logic [1:0]         access_size;
    logic [DATA_W-1:0]  write_data;
    logic [REQ_W-1:0]   request_bits;
  } item_t;

  typedef struct packed {
    logic [15:0] enable_mask;
    logic [15:0] pending_flags;
    logic [15:0] wait_control;
    logic [15:0] master_enable;
    logic [7:0]  post_boot_flag;
    logic [7:0]  halt_control;
    logic        halted;
  } regs_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              open_bus;
    logic              irq_raised;
    logic              halt_wakeup;
    logic              halt_entered;
  } result_t;

endpackage

`default_nettype wire

/* hdl/interrupt_halt_register_block_top.sv */
// Interrupt enable/flag, wait control and halt register block.
//
// Input channel (in_valid / in_stall): one beat is a bus read, a bus write or an
// interrupt request event, carried on kind, addr_offset, access_size, write_data and
// request_bits. A beat is taken at a clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): exactly one result beat per input beat, in
// order: read_data, open_bus, irq_raised, halt_wakeup, halt_entered.
// A taken beat moves from the input register into the result register, which drives the outputs.
// Throughput: one beat per cycle while the receiver does not stall, set by the single decode
// stage between the input register and the result register; register state is updated as a
// beat moves into the result register, so the following beat already sees it.
// When the receiver stalls, the result register holds its beat and the input register
// still takes one more beat; in_stall rises only when both are full.
// Reset (rst, synchronous, active high) empties both stages and clears all registers
// (enable mask, flags, wait control, master enable, post-boot flag, halt control, halted).
`timescale 1ns / 1ps
`default_nettype none

module interrupt_halt_register_block_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [9:0]  addr_offset,
  input  logic [1:0]  access_size,
  input  logic [31:0] write_data,
  input  logic [15:0] request_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        open_bus,
  output logic        irq_raised,
  output logic        halt_wakeup,
  output logic        halt_entered
);

  ihrb_pkg::item_t   item_in;
  ihrb_pkg::item_t   s1_item;
  logic              s1_valid;
  ihrb_pkg::regs_t   regs;
  ihrb_pkg::regs_t   regs_next;
  ihrb_pkg::result_t res;
  ihrb_pkg::result_t res_q;
  logic              advance;

  // input beat packing
  always_comb begin
    item_in.kind         = ihrb_pkg::kind_t'(kind);
    item_in.addr_offset  = addr_offset;
    item_in.access_size  = access_size;
    item_in.write_data   = write_data;
    item_in.request_bits = request_bits;
  end

  // flow control
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  ihrb_core u_core (
    .item      (s1_item),
    .regs      (regs),
    .regs_next (regs_next),
    .res       (res)
  );

  // stage valids and register state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      regs      <= '0;
    end else begin
      if (!in_stall) s1_valid <= in_valid;
      if (advance) out_valid <= s1_valid;
      if (advance && s1_valid) regs <= regs_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_item <= item_in;
    if (advance && s1_valid) res_q <= res;
  end

  assign read_data    = res_q.read_data;
  assign open_bus     = res_q.open_bus;
  assign irq_raised   = res_q.irq_raised;
  assign halt_wakeup  = res_q.halt_wakeup;
  assign halt_entered = res_q.halt_entered;

endmodule

`default_nettype wire

/* hdl/ihrb_core.sv */
// combinational access decode: read assembly, register writes, irq and halt checks
// depends on ihrb_pkg
`timescale 1ns / 1ps
`default_nettype none

module ihrb_core (
  input  ihrb_pkg::item_t   item,
  input  ihrb_pkg::regs_t   regs,
  output ihrb_pkg::regs_t   regs_next,
  output ihrb_pkg::result_t res
);

  // one register byte as seen by the bus
  function automatic logic [7:0] get_byte(input logic [ihrb_pkg::ADDR_W-1:0] a,
                                          input ihrb_pkg::regs_t r);
    logic [7:0] b;
    case (a)
      ihrb_pkg::A_EN:      b = r.enable_mask[7:0];
      ihrb_pkg::A_EN_HI:   b = r.enable_mask[15:8];
      ihrb_pkg::A_IF:      b = r.pending_flags[7:0];
      ihrb_pkg::A_IF_HI:   b = r.pending_flags[15:8];
      ihrb_pkg::A_WAIT:    b = r.wait_control[7:0];
      ihrb_pkg::A_WAIT_HI: b = r.wait_control[15:8];
      ihrb_pkg::A_IME:     b = r.master_enable[7:0];
      ihrb_pkg::A_IME_HI:  b = r.master_enable[15:8];
      ihrb_pkg::A_POST:    b = r.post_boot_flag;
      ihrb_pkg::A_HALT:    b = r.halt_control;
      default:             b = 8'h00;
    endcase
    return b;
  endfunction

  logic [ihrb_pkg::ADDR_W-1:0] a;
  logic [ihrb_pkg::ADDR_W-1:0] last;
  logic [2:0]                  nbytes;
  logic                        ack_wr;
  logic                        halt_wr;
  logic [31:0]                 rd_bytes;

  // access span
  always_comb begin
    a = {1'b0, item.addr_offset};
    case (item.access_size)
      ihrb_pkg::SIZE_BYTE: nbytes = 3'd1;
      ihrb_pkg::SIZE_HALF: nbytes = 3'd2;
      default:             nbytes = 3'd4;
    endcase
    last    = a + {{(ihrb_pkg::ADDR_W-3){1'b0}}, nbytes} - 11'd1;
    ack_wr  = (a <= ihrb_pkg::A_IF) && (last >= ihrb_pkg::A_IF);
    halt_wr = (a <= ihrb_pkg::A_HALT) && (last >= ihrb_pkg::A_HALT);
  end

  // little-endian byte assembly for reads
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < nbytes) begin
        rd_bytes[8*i +: 8] = get_byte(a + 11'(i), regs);
      end else begin
        rd_bytes[8*i +: 8] = 8'h00;
      end
    end
  end

  // state update and result flags
  always_comb begin
    logic [ihrb_pkg::ADDR_W-1:0] ba;
    logic [7:0]                  wb;
    logic                        pend;
    regs_next = regs;
    res       = '0;
    ba        = '0;
    wb        = '0;
    pend      = 1'b0;
    case (item.kind)
      ihrb_pkg::KIND_READ: begin
        if (a < ihrb_pkg::A_EN) begin
          res.open_bus = 1'b1;
        end else if (a >= ihrb_pkg::A_WAIT && a < ihrb_pkg::A_IME) begin
          if (a >= ihrb_pkg::A_WAIT_END) res.open_bus = 1'b1;
          else if (nbytes != 3'd4)       res.read_data = rd_bytes;
        end else if (a >= ihrb_pkg::A_IME && a < ihrb_pkg::A_POST) begin
          if (a >= ihrb_pkg::A_IME_END) res.open_bus = 1'b1;
          else if (nbytes != 3'd4)      res.read_data = rd_bytes;
        end else if (a >= ihrb_pkg::A_POST) begin
          if (a >= ihrb_pkg::A_POST_END) res.open_bus = 1'b1;
          else if (nbytes == 3'd1 && a != ihrb_pkg::A_HALT) res.read_data = rd_bytes;
        end else begin
          res.read_data = rd_bytes;
        end
      end
      ihrb_pkg::KIND_WRITE: begin
        // flag acknowledge covers the flag register; other bytes are not stored, save a word write's enable mask
        if (ack_wr) begin
          if (nbytes == 3'd1) begin
            if (a == ihrb_pkg::A_IF) begin
              regs_next.pending_flags = regs.pending_flags & ~{8'h00, item.write_data[7:0]};
            end else begin
              regs_next.pending_flags = regs.pending_flags & ~{item.write_data[7:0], 8'h00};
            end
          end else if (nbytes == 3'd2) begin
            regs_next.pending_flags = regs.pending_flags & ~item.write_data[15:0];
          end else begin
            regs_next.enable_mask   = item.write_data[15:0];
            regs_next.pending_flags = regs.pending_flags & ~item.write_data[31:16];
          end
        end else begin
          for (int i = 0; i < 4; i++) begin
            ba = a + 11'(i);
            wb = item.write_data[8*i +: 8];
            if (3'(i) < nbytes) begin
              case (ba)
                ihrb_pkg::A_EN:      regs_next.enable_mask[7:0]    = wb;
                ihrb_pkg::A_EN_HI:   regs_next.enable_mask[15:8]   = wb;
                ihrb_pkg::A_WAIT:    regs_next.wait_control[7:0]   = wb;
                ihrb_pkg::A_WAIT_HI: regs_next.wait_control[15:8]  = wb;
                ihrb_pkg::A_IME:     regs_next.master_enable[7:0]  = wb;
                ihrb_pkg::A_IME_HI:  regs_next.master_enable[15:8] = wb;
                ihrb_pkg::A_POST:    regs_next.post_boot_flag      = wb;
                ihrb_pkg::A_HALT:    regs_next.halt_control        = wb;
                default:             ;
              endcase
            end
          end
        end
        pend = |(regs_next.pending_flags & regs_next.enable_mask);
        if (halt_wr) begin
          // halt entry, stop mode ignored
          if (!regs_next.halt_control[ihrb_pkg::HALT_STOP_BIT] && !pend) begin
            regs_next.halted = 1'b1;
            res.halt_entered = 1'b1;
          end
        end else if (pend) begin
          res.irq_raised   = regs_next.master_enable[ihrb_pkg::IME_ON_BIT];
          res.halt_wakeup  = !regs_next.master_enable[ihrb_pkg::IME_ON_BIT] && regs.halted;
          regs_next.halted = 1'b0;
        end
      end
      ihrb_pkg::KIND_IRQ: begin
        regs_next.pending_flags = regs.pending_flags | item.request_bits;
        pend = |(regs_next.pending_flags & regs.enable_mask);
        if (pend) begin
          res.irq_raised   = regs.master_enable[ihrb_pkg::IME_ON_BIT];
          res.halt_wakeup  = !regs.master_enable[ihrb_pkg::IME_ON_BIT] && regs.halted;
          regs_next.halted = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/ihrb_checker.sv */
// port-level checks of the interrupt/halt register block, bound to the top level
// depends on interrupt_halt_register_block_top_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "interrupt_halt_register_block_top_macros.svh"

module ihrb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] read_data,
  input logic        open_bus,
  input logic        irq_raised,
  input logic        halt_wakeup,
  input logic        halt_entered
);

  // stalled result beat is held
  `IHRB_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(read_data), "stalled result beat changed")

  // open bus reads return zero data and raise no irq or wakeup
  `IHRB_ASSERT(a_open_zero, clk, rst, out_valid && open_bus |-> read_data == 32'h0 && !irq_raised && !halt_wakeup, "open bus beat carries data or irq")

  // halt entry never coincides with an irq, a wakeup or an open bus
  `IHRB_ASSERT(a_halt_excl, clk, rst, out_valid && halt_entered |-> !irq_raised && !halt_wakeup && !open_bus, "halt entry mixed with irq")

  // the result stage is empty and in_stall is low right after reset
  `IHRB_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid && !in_stall, "block not empty after reset")

endmodule

bind interrupt_halt_register_block_top ihrb_checker u_ihrb_checker (.*);

`default_nettype wire

/* tb/interrupt_halt_register_block_top_tb.sv */
// self-checking testbench for the interrupt/halt register block: directed and random beats
// depends on ihrb_pkg and interrupt_halt_register_block_top
`timescale 1ns / 1ps

module interrupt_halt_register_block_top_tb;
  import ihrb_pkg::*;

  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_WIDE = 2'd3;
  localparam int unsigned LAST_OFFSET = 10'h3FF;
  localparam int LONG_HOLD = 48;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = 2'd0;
  logic [9:0]  addr_offset = 10'd0;
  logic [1:0]  access_size = 2'd0;
  logic [31:0] write_data = 32'd0;
  logic [15:0] request_bits = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_data;
  logic        open_bus;
  logic        irq_raised;
  logic        halt_wakeup;
  logic        halt_entered;

  interrupt_halt_register_block_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .addr_offset(addr_offset), .access_size(access_size),
    .write_data(write_data), .request_bits(request_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .open_bus(open_bus), .irq_raised(irq_raised),
    .halt_wakeup(halt_wakeup), .halt_entered(halt_entered)
  );

  // shadow copy of the register file, updated as beats are accepted
  regs_t   shadow = '0;
  item_t   beats_to_send[$];
  result_t awaited_results[$];
  item_t   cur_beat;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      hold_kick = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  int      quiet_cycles = 0;
  int      mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // pending-and-enabled check: returns {irq, wakeup} and leaves halt
  function automatic logic [1:0] service_pending();
    logic [1:0] fired;
    fired = 2'b00;
    if ((shadow.pending_flags & shadow.enable_mask) != 16'h0) begin
      if (shadow.master_enable[IME_ON_BIT]) fired[1] = 1'b1;
      else if (shadow.halted) fired[0] = 1'b1;
      shadow.halted = 1'b0;
    end
    return fired;
  endfunction

  // expected result of one beat, with its register side effects
  function automatic result_t predict_bus_beat(item_t it);
    result_t     r;
    int unsigned a, n, last, i;
    logic [7:0]  b;
    logic [31:0] d;
    logic        assemble, ack, halt_wr;
    r = '0;
    a = it.addr_offset;
    d = it.write_data;
    n = (it.access_size == SIZE_BYTE) ? 1 : (it.access_size == SIZE_HALF) ? 2 : 4;
    last = a + n - 1;
    case (it.kind)
      KIND_READ: begin
        assemble = 1'b1;
        if (a < A_EN) begin
          r.open_bus = 1'b1;
          assemble = 1'b0;
        end else if (a >= A_WAIT && a < A_IME) begin
          r.open_bus = (a >= A_WAIT_END);
          assemble = (a < A_WAIT_END) && (n != 4);
        end else if (a >= A_IME && a < A_POST) begin
          r.open_bus = (a >= A_IME_END);
          assemble = (a < A_IME_END) && (n != 4);
        end else if (a >= A_POST) begin
          r.open_bus = (a >= A_POST_END);
          assemble = (a < A_POST_END) && (n == 1) && (a != A_HALT);
        end
        if (assemble) begin
          for (i = 0; i < n; i++) begin
            case (a + i)
              A_EN:      b = shadow.enable_mask[7:0];
              A_EN_HI:   b = shadow.enable_mask[15:8];
              A_IF:      b = shadow.pending_flags[7:0];
              A_IF_HI:   b = shadow.pending_flags[15:8];
              A_WAIT:    b = shadow.wait_control[7:0];
              A_WAIT_HI: b = shadow.wait_control[15:8];
              A_IME:     b = shadow.master_enable[7:0];
              A_IME_HI:  b = shadow.master_enable[15:8];
              A_POST:    b = shadow.post_boot_flag;
              A_HALT:    b = shadow.halt_control;
              default:   b = 8'h00;
            endcase
            r.read_data[8*i +: 8] = b;
          end
        end
      end
      KIND_WRITE: begin
        ack = (a <= A_IF) && (A_IF <= last);
        halt_wr = (a <= A_HALT) && (A_HALT <= last);
        // writes covering the flags acknowledge instead of storing, but a word write also sets the enable mask
        if (ack) begin
          if (n == 1) begin
            if (a == A_IF) shadow.pending_flags &= ~{8'h00, d[7:0]};
            else shadow.pending_flags &= ~{d[7:0], 8'h00};
          end else if (n == 2) begin
            shadow.pending_flags &= ~d[15:0];
          end else begin
            shadow.enable_mask = d[15:0];
            shadow.pending_flags &= ~d[31:16];
          end
        end else begin
          for (i = 0; i < n; i++) begin
            b = d[8*i +: 8];
            case (a + i)
              A_EN:      shadow.enable_mask[7:0] = b;
              A_EN_HI:   shadow.enable_mask[15:8] = b;
              A_WAIT:    shadow.wait_control[7:0] = b;
              A_WAIT_HI: shadow.wait_control[15:8] = b;
              A_IME:     shadow.master_enable[7:0] = b;
              A_IME_HI:  shadow.master_enable[15:8] = b;
              A_POST:    shadow.post_boot_flag = b;
              A_HALT:    shadow.halt_control = b;
              default:   ;
            endcase
          end
        end
        if (halt_wr) begin
          if (!shadow.halt_control[HALT_STOP_BIT] &&
              (shadow.pending_flags & shadow.enable_mask) == 16'h0) begin
            shadow.halted = 1'b1;
            r.halt_entered = 1'b1;
          end
        end else begin
          {r.irq_raised, r.halt_wakeup} = service_pending();
        end
      end
      KIND_IRQ: begin
        shadow.pending_flags |= it.request_bits;
        {r.irq_raised, r.halt_wakeup} = service_pending();
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t bus_beat(kind_t k, int unsigned a, logic [1:0] sz,
                                     logic [31:0] d, logic [15:0] q);
    item_t it;
    it.kind = k;
    it.addr_offset = a[9:0];
    it.access_size = sz;
    it.write_data = d;
    it.request_bits = q;
    return it;
  endfunction

  // random beat, mostly aimed at the mapped register windows
  function automatic item_t random_bus_beat();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 35) it.kind = KIND_READ;
    else if (pick < 75) it.kind = KIND_WRITE;
    else if (pick < 95) it.kind = KIND_IRQ;
    else it.kind = KIND_NOP;
    pick = $urandom_range(9, 0);
    if (pick < 6) it.addr_offset = 10'h1FE + 10'($urandom_range(13, 0));
    else if (pick < 8) it.addr_offset = 10'h2FD + 10'($urandom_range(7, 0));
    else it.addr_offset = 10'($urandom_range(1023, 0));
    pick = $urandom_range(15, 0);
    it.access_size = (pick == 15) ? SIZE_WIDE : 2'(pick % 3);
    case ($urandom_range(3, 0))
      0:       it.write_data = 32'hFFFF_FFFF;
      1:       it.write_data = 32'h0;
      default: it.write_data = $urandom;
    endcase
    if ($urandom_range(3, 0) == 0) it.request_bits = 16'h1 << $urandom_range(15, 0);
    else it.request_bits = 16'($urandom);
    return it;
  endfunction

  task automatic queue_random_beats(int count);
    repeat (count) beats_to_send.push_back(random_bus_beat());
  endtask

  // waits until nothing is left to send and every result is back
  task automatic wait_idle();
    do @(negedge clk);
    while (beats_to_send.size() != 0 || in_valid || awaited_results.size() != 0);
  endtask

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
  endtask

  // driver: predict on accept, then offer the next beat or idle
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        awaited_results.push_back(predict_bus_beat(cur_beat));
      if (!in_valid || !in_stall) begin
        if (beats_to_send.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
          cur_beat = beats_to_send.pop_front();
          kind <= cur_beat.kind;
          addr_offset <= cur_beat.addr_offset;
          access_size <= cur_beat.access_size;
          write_data <= cur_beat.write_data;
          request_bits <= cur_beat.request_bits;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: random, plus a long hold-off when kicked
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
    end else if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left = LONG_HOLD;
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99, 0) < rx_idle_pct);
  end

  // result checker
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report("result beat with nothing outstanding", 32'h0, read_data);
      end else begin
        want = awaited_results.pop_front();
        if (read_data !== want.read_data) report("read_data", want.read_data, read_data);
        if (open_bus !== want.open_bus) report("open_bus", want.open_bus, open_bus);
        if (irq_raised !== want.irq_raised) report("irq_raised", want.irq_raised, irq_raised);
        if (halt_wakeup !== want.halt_wakeup)
          report("halt_wakeup", want.halt_wakeup, halt_wakeup);
        if (halt_entered !== want.halt_entered)
          report("halt_entered", want.halt_entered, halt_entered);
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL interrupt_halt_register_block_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed beats: reset values, open bus, halt and wake paths, flag acks
    tx_idle_pct = 32;
    rx_idle_pct = 65;
    beats_to_send.push_back(bus_beat(KIND_READ, A_EN, SIZE_WORD, 32'h0, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_READ, A_EN - 1, SIZE_BYTE, 32'h0, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_READ, A_WAIT_END, SIZE_HALF, 32'h0, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_READ, LAST_OFFSET, SIZE_WIDE, 32'h0, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_IRQ, 10'h0, SIZE_BYTE, 32'h0, 16'hFFFF));
    beats_to_send.push_back(bus_beat(KIND_READ, A_EN, SIZE_WORD, 32'h0, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_WRITE, A_HALT, SIZE_BYTE, 32'h0, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_WRITE, A_EN, SIZE_WORD, 32'h0000_FFFF, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_WRITE, A_HALT, SIZE_BYTE, 32'h0, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_WRITE, A_IF, SIZE_HALF, 32'hFFFF_FFFF, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_WRITE, A_HALT, SIZE_BYTE, 32'h80, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_WRITE, A_POST, SIZE_HALF, 32'h0055, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_READ, A_POST, SIZE_BYTE, 32'h0, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_READ, A_HALT, SIZE_BYTE, 32'h0, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_IRQ, 10'h0, SIZE_BYTE, 32'h0, 16'h0001));
    beats_to_send.push_back(bus_beat(KIND_WRITE, A_IME, SIZE_BYTE, 32'h01, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_IRQ, 10'h0, SIZE_BYTE, 32'h0, 16'h8000));
    beats_to_send.push_back(bus_beat(KIND_WRITE, A_IF, SIZE_BYTE, 32'hFF, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_WRITE, A_EN_HI, SIZE_HALF, 32'hFFFF, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_WRITE, A_IF_HI, SIZE_WORD, 32'hDEAD_BEEF, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_READ, A_WAIT, SIZE_HALF, 32'h0, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_READ, A_WAIT, SIZE_WORD, 32'h0, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_WRITE, A_EN - 1, SIZE_WORD, 32'h1234_5678, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_WRITE, A_POST - 2, SIZE_WORD, 32'hFFFF_FFFF, 16'h0));
    beats_to_send.push_back(bus_beat(KIND_NOP, LAST_OFFSET, SIZE_WIDE, 32'hFFFF_FFFF,
                                     16'hFFFF));

    // sender idles less, receiver more
    queue_random_beats(400);
    wait_idle();

    // long receiver hold-off while the sender keeps offering
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_kick++;
    queue_random_beats(40);
    wait_idle();

    // sender idles more, receiver less
    tx_idle_pct = 65;
    rx_idle_pct = 32;
    queue_random_beats(400);
    wait_idle();

    // back to back
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_beats(400);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS interrupt_halt_register_block_top");
    else
      $display("FAIL interrupt_halt_register_block_top");
    $finish;
  end

endmodule
